### design/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define HMU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HMU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/hmu_pkg.sv
// ----------------------------------------------------------------------------
// hmu_pkg
// Types and codes shared by the lock unit, its wait chain and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hmu_pkg;

   localparam int OP_W     = 3;
   localparam int TID_W    = 4;
   localparam int STATUS_W = 4;
   localparam int NEST_W   = 8;
   localparam int WAIT_W   = 5;
   localparam int CONT_W   = 32;

   // Operation codes of a request.
   localparam logic [OP_W-1:0] OP_LOCK    = 3'd0;
   localparam logic [OP_W-1:0] OP_TRYLOCK = 3'd1;
   localparam logic [OP_W-1:0] OP_UNLOCK  = 3'd2;
   localparam logic [OP_W-1:0] OP_RLOCK   = 3'd3;
   localparam logic [OP_W-1:0] OP_RUNLOCK = 3'd4;

   // Status codes of a result.
   localparam logic [STATUS_W-1:0] ST_ACQUIRED   = 4'd0;
   localparam logic [STATUS_W-1:0] ST_NESTED     = 4'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUED     = 4'd2;
   localparam logic [STATUS_W-1:0] ST_TRY_FAILED = 4'd3;
   localparam logic [STATUS_W-1:0] ST_FREED      = 4'd4;
   localparam logic [STATUS_W-1:0] ST_HANDED     = 4'd5;
   localparam logic [STATUS_W-1:0] ST_STILL_HELD = 4'd6;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 4'd7;
   localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 4'd8;

   typedef logic [TID_W-1:0] tid_type;

   // Command broadcast along the wait chain.
   typedef struct packed {
      logic    push;
      logic    pop;
      tid_type tid;
   } chain_cmd_type;

endpackage

`default_nettype wire

### design/hmu_cell.sv
// ----------------------------------------------------------------------------
// hmu_cell
// One slot of the wait chain: holds the identity of one waiting task.
// ----------------------------------------------------------------------------
`default_nettype none

module hmu_cell (
   input  wire logic                  clock,
   input  wire hmu_pkg::chain_cmd_type cmd,
   input  wire logic                  tail_sel,
   input  wire hmu_pkg::tid_type      next_tid,
   output hmu_pkg::tid_type           tid
);

   hmu_pkg::tid_type tid_ff;
   hmu_pkg::tid_type tid_in;

   // A pop moves every slot one place towards the head; a push fills the
   // first free slot.
   always_comb begin
      tid_in = tid_ff;
      if (cmd.pop) begin
         tid_in = next_tid;
      end else if (cmd.push && tail_sel) begin
         tid_in = cmd.tid;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff <= tid_in;
   end

   assign tid = tid_ff;

endmodule

`default_nettype wire

### design/hmu_wait_chain.sv
// ----------------------------------------------------------------------------
// hmu_wait_chain
// Row of cells forming the FIFO of waiting tasks, head at cell zero.
// ----------------------------------------------------------------------------
`default_nettype none

module hmu_wait_chain #(
   parameter int TASKS = 16
) (
   input  wire logic                         clock,
   input  wire hmu_pkg::chain_cmd_type        cmd,
   input  wire logic [$clog2(TASKS+1)-1:0]   fill,
   output hmu_pkg::tid_type                  head_tid
);

   localparam int FILL_W = $clog2(TASKS + 1);

   hmu_pkg::tid_type cell_tid [TASKS];

   for (genvar i = 0; i < TASKS; i++) begin : g_cell
      hmu_pkg::tid_type next_tid;
      logic             tail_sel;

      if (i < TASKS - 1) begin : g_inner
         assign next_tid = cell_tid[i+1];
      end else begin : g_last
         assign next_tid = cell_tid[i];
      end

      // The first free slot sits at the current fill level.
      assign tail_sel = (fill == FILL_W'(i));

      hmu_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .tail_sel (tail_sel),
         .next_tid (next_tid),
         .tid      (cell_tid[i])
      );
   end

   assign head_tid = cell_tid[0];

endmodule

`default_nettype wire

### design/fifo_handoff_mutex_unit.sv
// ----------------------------------------------------------------------------
// fifo_handoff_mutex_unit
// Lock unit for one recursive mutex with a first-in first-out wait queue.
// Each request carries an operation (lock, trylock, unlock, recursive lock,
// recursive unlock) and the identity of the requesting task, and gives
// exactly one result. A free lock is granted; a held lock places the
// requester at the tail of the wait queue and counts one contention, unless
// the queue is full. Releasing the lock hands it straight to the head waiter,
// reported as woken, or frees it. One request is taken in every clock cycle
// unless a result is stalled: the whole decision is made in the cycle of
// acceptance and the wait queue, a chain of TASKS cells that shift one place
// towards the head on a handover, moves in that same cycle. The result
// appears in an output register in the cycle after acceptance, and a new
// request is taken while that result waits as long as the result is taken
// in the same cycle. Parameters: TASKS sets the depth of the wait queue,
// COUNT_BITS the width of the nesting count, which saturates at all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_handoff_mutex_unit #(
   parameter int TASKS      = 16,
   parameter int COUNT_BITS = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [hmu_pkg::OP_W-1:0]          req_op,
   input  wire logic [hmu_pkg::TID_W-1:0]         req_task_id,
   // Result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [hmu_pkg::STATUS_W-1:0]           rsp_status,
   output logic                                   rsp_woken_valid,
   output logic [hmu_pkg::TID_W-1:0]              rsp_woken_task,
   output logic                                   rsp_held,
   output logic [hmu_pkg::TID_W-1:0]              rsp_owner_task,
   output logic [hmu_pkg::NEST_W-1:0]             rsp_nesting,
   output logic [hmu_pkg::WAIT_W-1:0]             rsp_waiter_count,
   output logic [hmu_pkg::CONT_W-1:0]             rsp_contentions
);

   localparam int FILL_W = $clog2(TASKS + 1);
   localparam logic [FILL_W-1:0]     FILL_FULL = FILL_W'(TASKS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // Lock state.
   logic                          held_ff,  held_in;
   hmu_pkg::tid_type              owner_ff, owner_in;
   logic [COUNT_BITS-1:0]         hold_ff,  hold_in;
   logic [FILL_W-1:0]             fill_ff,  fill_in;
   logic [hmu_pkg::CONT_W-1:0]    cont_ff,  cont_in;

   // Output register.
   logic                          rsp_valid_ff,  rsp_valid_in;
   logic [hmu_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic                          rsp_woken_valid_ff, rsp_woken_valid_in;
   hmu_pkg::tid_type              rsp_woken_task_ff,  rsp_woken_task_in;

   logic                          req_accept;
   logic                          is_owner;
   logic                          want_acquire;
   logic                          want_release;
   hmu_pkg::chain_cmd_type        chain_cmd;
   hmu_pkg::tid_type              head_tid;

   // The output register is free when empty or being emptied this cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign is_owner   = held_ff && (owner_ff == req_task_id);

   // Decision for the request at the port. Acquire and release are shared by
   // several operations, so the case statement only raises a flag for them.
   always_comb begin
      held_in       = held_ff;
      owner_in      = owner_ff;
      hold_in       = hold_ff;
      fill_in       = fill_ff;
      cont_in       = cont_ff;
      rsp_status_in = hmu_pkg::ST_NOT_OWNER;
      rsp_woken_valid_in = 1'b0;
      rsp_woken_task_in  = '0;
      want_acquire  = 1'b0;
      want_release  = 1'b0;
      chain_cmd.push = 1'b0;
      chain_cmd.pop  = 1'b0;
      chain_cmd.tid  = req_task_id;

      case (req_op)
         hmu_pkg::OP_LOCK: begin
            want_acquire = 1'b1;
         end
         hmu_pkg::OP_TRYLOCK: begin
            if (!held_ff) begin
               want_acquire = 1'b1;
            end else begin
               rsp_status_in = hmu_pkg::ST_TRY_FAILED;
            end
         end
         hmu_pkg::OP_UNLOCK: begin
            // A plain unlock by the owner releases every nesting level.
            want_release = is_owner;
         end
         hmu_pkg::OP_RLOCK: begin
            if (is_owner) begin
               if (hold_ff < COUNT_MAX) begin
                  hold_in = hold_ff + COUNT_ONE;
               end
               rsp_status_in = hmu_pkg::ST_NESTED;
            end else begin
               want_acquire = 1'b1;
            end
         end
         hmu_pkg::OP_RUNLOCK: begin
            if (is_owner) begin
               if (hold_ff > COUNT_ONE) begin
                  hold_in       = hold_ff - COUNT_ONE;
                  rsp_status_in = hmu_pkg::ST_STILL_HELD;
               end else begin
                  want_release = 1'b1;
               end
            end
         end
         default: begin
            // Unknown operations leave everything unchanged.
         end
      endcase

      if (want_acquire) begin
         if (!held_ff) begin
            held_in       = 1'b1;
            owner_in      = req_task_id;
            hold_in       = COUNT_ONE;
            rsp_status_in = hmu_pkg::ST_ACQUIRED;
         end else if (fill_ff == FILL_FULL) begin
            // A full queue turns the requester away without counting it.
            rsp_status_in = hmu_pkg::ST_QUEUE_FULL;
         end else begin
            chain_cmd.push = 1'b1;
            fill_in        = fill_ff + FILL_W'(1);
            cont_in        = cont_ff + 32'd1;
            rsp_status_in  = hmu_pkg::ST_QUEUED;
         end
      end

      if (want_release) begin
         if (fill_ff != '0) begin
            // Ownership passes directly to the oldest waiter.
            chain_cmd.pop      = 1'b1;
            owner_in           = head_tid;
            hold_in            = COUNT_ONE;
            fill_in            = fill_ff - FILL_W'(1);
            rsp_woken_valid_in = 1'b1;
            rsp_woken_task_in  = head_tid;
            rsp_status_in      = hmu_pkg::ST_HANDED;
         end else begin
            held_in       = 1'b0;
            owner_in      = '0;
            hold_in       = '0;
            rsp_status_in = hmu_pkg::ST_FREED;
         end
      end

      // The queue only moves for a request that is actually taken.
      if (!req_accept) begin
         chain_cmd.push = 1'b0;
         chain_cmd.pop  = 1'b0;
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   hmu_wait_chain #(
      .TASKS (TASKS)
   ) u_wait_chain (
      .clock    (clock),
      .cmd      (chain_cmd),
      .fill     (fill_ff),
      .head_tid (head_tid)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         owner_ff     <= '0;
         hold_ff      <= '0;
         fill_ff      <= '0;
         cont_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            held_ff  <= held_in;
            owner_ff <= owner_in;
            hold_ff  <= hold_in;
            fill_ff  <= fill_in;
            cont_ff  <= cont_in;
         end
      end
   end

   // Result payload; the state fields show the state after the request.
   logic                          rsp_held_ff;
   hmu_pkg::tid_type              rsp_owner_ff;
   logic [hmu_pkg::NEST_W-1:0]    rsp_nesting_ff;
   logic [hmu_pkg::WAIT_W-1:0]    rsp_waiter_ff;
   logic [hmu_pkg::CONT_W-1:0]    rsp_cont_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_status_ff      <= rsp_status_in;
         rsp_woken_valid_ff <= rsp_woken_valid_in;
         rsp_woken_task_ff  <= rsp_woken_task_in;
         rsp_held_ff        <= held_in;
         rsp_owner_ff       <= owner_in;
         rsp_nesting_ff     <= hmu_pkg::NEST_W'(hold_in);
         rsp_waiter_ff      <= hmu_pkg::WAIT_W'(fill_in);
         rsp_cont_ff        <= cont_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_woken_valid  = rsp_woken_valid_ff;
   assign rsp_woken_task   = rsp_woken_task_ff;
   assign rsp_held         = rsp_held_ff;
   assign rsp_owner_task   = rsp_owner_ff;
   assign rsp_nesting      = rsp_nesting_ff;
   assign rsp_waiter_count = rsp_waiter_ff;
   assign rsp_contentions  = rsp_cont_ff;

endmodule

`default_nettype wire

### design/hmu_checker.sv
// ----------------------------------------------------------------------------
// hmu_checker
// Port-level checks on the lock unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hmu_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [hmu_pkg::STATUS_W-1:0]      rsp_status,
   input wire logic                              rsp_woken_valid,
   input wire logic                              rsp_held,
   input wire logic [hmu_pkg::TID_W-1:0]         rsp_owner_task,
   input wire logic [hmu_pkg::NEST_W-1:0]        rsp_nesting
);

   `HMU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status), "result dropped or changed while stalled")
   `HMU_ASSERT(a_woken_handover, clock, reset, rsp_valid && rsp_woken_valid |-> rsp_status == hmu_pkg::ST_HANDED, "woken task reported without handover")
   `HMU_ASSERT(a_free_clean, clock, reset, rsp_valid && !rsp_held |-> rsp_owner_task == '0 && rsp_nesting == '0, "free lock shows owner or nesting")
   `HMU_ASSERT(a_grant_once, clock, reset, rsp_valid && (rsp_status == hmu_pkg::ST_ACQUIRED || rsp_status == hmu_pkg::ST_HANDED) |-> rsp_held && rsp_nesting == 8'd1, "new owner without single hold")
   `HMU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result pending after reset")

endmodule

bind fifo_handoff_mutex_unit hmu_checker u_hmu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_status      (rsp_status),
   .rsp_woken_valid (rsp_woken_valid),
   .rsp_held        (rsp_held),
   .rsp_owner_task  (rsp_owner_task),
   .rsp_nesting     (rsp_nesting)
);

`default_nettype wire
